// ----- src/sfbr_pkg.sv -----
// Shared types, constants and the CRC-16 byte update of the sync frame bit receiver.
package sfbr_pkg;

    localparam int FRAME_BYTES = 10;
    localparam int IDX_W       = $clog2(FRAME_BYTES);
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [15:0] CRC_POLY     = 16'h1021;
    localparam logic [15:0] BIT_PERIOD_RST = 16'd6104;
    localparam logic [14:0] HALF_BIT_RST   = 15'd3052;
    localparam logic [15:0] SYNC_MIN_RST   = 16'd227;

    localparam logic [CFG_IDX_W-1:0] REG_BIT_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_BIT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_MIN   = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WAIT,
        S_SYNC,
        S_START,
        S_BIT,
        S_READ,
        S_SEND
    } t_state;

    typedef struct packed {
        logic tick_clr;
        logic tick_inc;
        logic load_half;
        logic next_adv;
        logic byte_clr;
        logic shift_in;
        logic store_byte;
        logic emit_clr;
        logic emit_inc;
    } t_cmd;

    typedef struct packed {
        logic ge_min;
        logic due;
        logic bit_lt8;
        logic frame_end;
        logic emit_last;
    } t_status;

    // MSB-first CRC-16 over one byte.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        c = crc ^ {data, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ----- src/sfbr_ram.sv -----
// Generic simple dual-port RAM with registered read.
module sfbr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
endmodule

// ----- src/sfbr_ctrl.sv -----
// Receiver controller: phase sequencing and frame readout handshakes.
module sfbr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_valid,
    input  logic             i_bit,
    input  logic             i_m_ready,
    input  sfbr_pkg::t_status i_status,
    output sfbr_pkg::t_cmd   o_cmd,
    output logic             o_s_ready,
    output logic             o_m_valid
);
    import sfbr_pkg::*;

    t_state r_state, n_state;
    logic   acc;
    t_cmd   cmd;

    assign o_s_ready = (r_state != S_READ) && (r_state != S_SEND);
    assign o_m_valid = (r_state == S_SEND);
    assign acc       = i_s_valid && o_s_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_WAIT: begin
                if (acc && i_bit) n_state = S_SYNC;
            end
            S_SYNC: begin
                if (acc && !i_bit) n_state = i_status.ge_min ? S_START : S_WAIT;
            end
            S_START: begin
                if (acc && i_status.due) n_state = i_bit ? S_IDLE : S_BIT;
            end
            S_BIT: begin
                if (acc && i_status.due && !i_status.bit_lt8) begin
                    if (i_bit) n_state = S_IDLE;
                    else if (i_status.frame_end) n_state = S_READ;
                end
            end
            S_READ: n_state = S_SEND;
            S_SEND: begin
                if (i_m_ready) n_state = i_status.emit_last ? S_IDLE : S_READ;
            end
            default: begin
                // idle and unused codes
                n_state = (acc && !i_bit) ? S_WAIT : S_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd = '0;
        unique case (r_state)
            S_WAIT: begin
                cmd.tick_inc = acc && i_bit;
            end
            S_SYNC: begin
                cmd.tick_inc  = acc && i_bit;
                cmd.tick_clr  = acc && !i_bit;
                cmd.load_half = acc && !i_bit && i_status.ge_min;
            end
            S_START: begin
                cmd.tick_inc = acc;
                cmd.next_adv = acc && i_status.due;
                cmd.byte_clr = acc && i_status.due && !i_bit;
            end
            S_BIT: begin
                cmd.tick_inc   = acc;
                cmd.next_adv   = acc && i_status.due;
                cmd.shift_in   = acc && i_status.due && i_status.bit_lt8;
                cmd.store_byte = acc && i_status.due && !i_status.bit_lt8 && !i_bit;
                cmd.byte_clr   = cmd.store_byte && i_status.frame_end;
                cmd.emit_clr   = cmd.store_byte && i_status.frame_end;
            end
            S_READ: begin
            end
            S_SEND: begin
                cmd.emit_inc = i_m_ready && !i_status.emit_last;
            end
            default: begin
                cmd.tick_clr = acc && !i_bit;
            end
        endcase
    end

    assign o_cmd = cmd;

`ifndef NO_ASSERTIONS
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_ready && o_m_valid))
        else $error("input accepted during frame readout");
    a_tick_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.tick_clr && o_cmd.tick_inc))
        else $error("tick counter cleared and incremented together");
    a_frame_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.store_byte && i_status.frame_end) |=> (r_state == S_READ))
        else $error("frame end did not start readout");
    a_frame_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_valid && i_m_ready && i_status.emit_last) |=> (r_state == S_IDLE))
        else $error("last byte did not return to idle");
`endif
endmodule

// ----- src/sfbr_datapath.sv -----
// Receiver datapath: config registers, timing counters, byte shifter, CRC and frame store.
module sfbr_datapath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [sfbr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [sfbr_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_bit,
    input  sfbr_pkg::t_cmd                     i_cmd,
    output sfbr_pkg::t_status                  o_status,
    output logic [7:0]                         o_frame_byte,
    output logic [3:0]                         o_byte_index,
    output logic                               o_crc_ok
);
    import sfbr_pkg::*;

    logic [15:0]      r_bit_period;
    logic [14:0]      r_half_bit;
    logic [15:0]      r_sync_min;
    logic [15:0]      r_tick, n_tick;
    logic [23:0]      r_next, n_next;
    logic [3:0]       r_bit_cnt, n_bit_cnt;
    logic [7:0]       r_shift, n_shift;
    logic [IDX_W-1:0] r_byte_cnt, n_byte_cnt;
    logic [15:0]      r_crc, n_crc;
    logic [7:0]       r_rx_lo;
    logic             r_crc_ok;
    logic [IDX_W-1:0] r_emit_idx, n_emit_idx;

    logic [15:0] tick_up;
    logic [24:0] next_sum;

    assign tick_up  = (r_tick == 16'hFFFF) ? r_tick : r_tick + 16'd1;
    assign next_sum = {1'b0, r_next} + {9'd0, r_bit_period};

    assign o_status.ge_min    = (r_tick >= r_sync_min);
    assign o_status.due       = ({tick_up, 8'h00} >= r_next);
    assign o_status.bit_lt8   = (r_bit_cnt < 4'd8);
    assign o_status.frame_end = (r_byte_cnt == IDX_W'(FRAME_BYTES - 1));
    assign o_status.emit_last = (r_emit_idx == IDX_W'(FRAME_BYTES - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_period <= BIT_PERIOD_RST;
            r_half_bit   <= HALF_BIT_RST;
            r_sync_min   <= SYNC_MIN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_BIT_PERIOD: r_bit_period <= i_cfg_data;
                REG_HALF_BIT:   r_half_bit   <= i_cfg_data[14:0];
                REG_SYNC_MIN:   r_sync_min   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_tick     = r_tick;
        n_next     = r_next;
        n_bit_cnt  = r_bit_cnt;
        n_shift    = r_shift;
        n_byte_cnt = r_byte_cnt;
        n_crc      = r_crc;
        n_emit_idx = r_emit_idx;

        if (i_cmd.tick_clr) n_tick = 16'd0;
        else if (i_cmd.tick_inc) n_tick = tick_up;

        if (i_cmd.load_half) n_next = {9'd0, r_half_bit};
        else if (i_cmd.next_adv) n_next = next_sum[24] ? 24'hFFFFFF : next_sum[23:0];

        if (i_cmd.shift_in) begin
            n_shift   = {i_bit, r_shift[7:1]};
            n_bit_cnt = r_bit_cnt + 4'd1;
        end

        if (i_cmd.store_byte) begin
            n_shift    = 8'd0;
            n_bit_cnt  = 4'd0;
            n_byte_cnt = r_byte_cnt + IDX_W'(1);
            // checksum covers every byte but the trailing two
            if (r_byte_cnt < IDX_W'(FRAME_BYTES - 2)) n_crc = crc16_byte(r_crc, r_shift);
        end

        if (i_cmd.byte_clr) begin
            n_shift    = 8'd0;
            n_bit_cnt  = 4'd0;
            n_byte_cnt = '0;
            n_crc      = 16'd0;
        end

        if (i_cmd.emit_clr) n_emit_idx = '0;
        else if (i_cmd.emit_inc) n_emit_idx = r_emit_idx + IDX_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick     <= 16'd0;
            r_next     <= {9'd0, HALF_BIT_RST};
            r_bit_cnt  <= 4'd0;
            r_shift    <= 8'd0;
            r_byte_cnt <= '0;
            r_crc      <= 16'd0;
            r_emit_idx <= '0;
        end else begin
            r_tick     <= n_tick;
            r_next     <= n_next;
            r_bit_cnt  <= n_bit_cnt;
            r_shift    <= n_shift;
            r_byte_cnt <= n_byte_cnt;
            r_crc      <= n_crc;
            r_emit_idx <= n_emit_idx;
        end
    end

    // received checksum: low byte kept, high byte is the one being stored last
    always_ff @(posedge i_clk) begin
        if (i_cmd.store_byte && (r_byte_cnt == IDX_W'(FRAME_BYTES - 2))) begin
            r_rx_lo <= r_shift;
        end
        if (i_cmd.store_byte && o_status.frame_end) begin
            r_crc_ok <= ({r_shift, r_rx_lo} == r_crc);
        end
    end

    sfbr_ram #(
        .WIDTH (8),
        .DEPTH (FRAME_BYTES)
    ) u_frame_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.store_byte),
        .i_wr_addr (r_byte_cnt),
        .i_wr_data (r_shift),
        .i_rd_addr (r_emit_idx),
        .o_rd_data (o_frame_byte)
    );

    assign o_byte_index = 4'(r_emit_idx);
    assign o_crc_ok     = r_crc_ok;
endmodule

// ----- src/sync_frame_bit_receiver.sv -----
// Top level of the sync frame bit receiver.
// Takes one demodulated bit per input transaction: waits for a low sample, then a high sync
// run of at least sync_min_ticks samples, checks the start bit half_bit_q8/256 samples after
// the run ends and samples data bits every bit_period_q8/256 samples (Q8 timing). Frames are
// FRAME_BYTES bytes, LSB first, each followed by a separator bit that must be 0; a bad start or
// separator bit drops the frame without output. While receiving, a sample is taken every cycle
// in which the input is valid. A completed frame is read from the frame RAM one byte per output
// transaction; each byte goes through a read state for the registered RAM read and then a send
// state that output stalls hold; input tready is low during that readout. crc_ok (CRC-16,
// poly 0x1021, init 0, over all but the last two bytes, compared with those two bytes taken
// little-endian) is the same on every byte of a frame. Config writes are always ready.
module sync_frame_bit_receiver (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [sfbr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [sfbr_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [7:0]                          i_s_tdata,   // [0] sample_bit, [7:1] zero
    input  logic                                i_m_tready,
    output logic                                o_m_tvalid,
    output logic [15:0]                         o_m_tdata,   // [7:0] frame_byte, [11:8] byte_index
    output logic                                o_m_tlast,
    output logic                                o_m_tuser    // [0] crc_ok
);
    import sfbr_pkg::*;

    t_cmd        cmd;
    t_status     status;
    logic [7:0]  frame_byte;
    logic [3:0]  byte_index;

    assign o_cfg_ready = 1'b1;

    sfbr_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_tvalid),
        .i_bit     (i_s_tdata[0]),
        .i_m_ready (i_m_tready),
        .i_status  (status),
        .o_cmd     (cmd),
        .o_s_ready (o_s_tready),
        .o_m_valid (o_m_tvalid)
    );

    sfbr_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_bit        (i_s_tdata[0]),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_frame_byte (frame_byte),
        .o_byte_index (byte_index),
        .o_crc_ok     (o_m_tuser)
    );

    assign o_m_tdata = {4'd0, byte_index, frame_byte};
    assign o_m_tlast = status.emit_last;
endmodule

// ----- dv/tb.sv -----
// Self-checking testbench for the sync frame bit receiver: random bit streams against a predictor.
`timescale 1ns / 100ps

module tb;
    import sfbr_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int TAIL_CYCLES = 2 * FRAME_BYTES + 20;
    localparam int FRAME_BITS  = 1 + FRAME_BYTES * 9;   // start bit + data and separator bits
    localparam int N_ITEMS     = 370;

    typedef struct packed {
        logic [7:0] value;
        logic [3:0] index;
        logic       last;
        logic       crc_ok;
    } t_rx_byte;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_s_tvalid  = 1'b0;
    logic [7:0]            i_s_tdata   = 8'd0;
    logic                  i_m_tready  = 1'b0;
    logic                  o_cfg_ready;
    logic                  o_s_tready;
    logic                  o_m_tvalid;
    logic [15:0]           o_m_tdata;
    logic                  o_m_tlast;
    logic                  o_m_tuser;

    sync_frame_bit_receiver u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_m_tready  (i_m_tready),
        .o_m_tvalid  (o_m_tvalid),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .o_m_tuser   (o_m_tuser)
    );

    always #5 i_clk = ~i_clk;

    // stimulus and scoreboard storage
    logic       sample_q[$];
    t_rx_byte   pending_bytes[$];
    logic [7:0] tx_bytes [FRAME_BYTES];
    int         n_err = 0;
    int         gen_count = 0;
    int         gen_period = BIT_PERIOD_RST;
    int         gen_half = HALF_BIT_RST;
    bit         gaps_on = 1'b1;
    bit         sample_taken = 1'b0;
    bit         byte_taken = 1'b0;
    int         src_gap = 0;
    int         sink_gap = 0;

    // receiver state as predicted
    logic [15:0] cfg_period;
    logic [14:0] cfg_half;
    logic [15:0] cfg_sync_min;
    t_state      rx_phase;
    logic [15:0] rx_ticks;
    logic [23:0] rx_due_q8;
    logic [3:0]  rx_nbits;
    logic [7:0]  rx_shift;
    logic [3:0]  rx_nbytes;
    logic [7:0]  rx_store [FRAME_BYTES];

    function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] d);
        logic fb;
        for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ d[i];
            c = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return c;
    endfunction

    function automatic int draw_gap();
        int r;
        if (!gaps_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void check_field(input string what, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            n_err++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
        end
    endfunction

    task automatic reset_model();
        cfg_period   = BIT_PERIOD_RST;
        cfg_half     = HALF_BIT_RST;
        cfg_sync_min = SYNC_MIN_RST;
        rx_phase     = S_IDLE;
        rx_ticks     = '0;
        rx_due_q8    = {9'd0, HALF_BIT_RST};
        rx_nbits     = '0;
        rx_shift     = '0;
        rx_nbytes    = '0;
        for (int i = 0; i < FRAME_BYTES; i++) rx_store[i] = '0;
        pending_bytes.delete();
    endtask

    task automatic bump_tick();
        if (rx_ticks != 16'hFFFF) rx_ticks++;
    endtask

    // one tick in the start or bit phase; true when this tick is a sampling instant
    task automatic sample_due(output bit due);
        logic [24:0] sum;
        bump_tick();
        due = ({rx_ticks, 8'h00} >= rx_due_q8);
        if (due) begin
            sum = {1'b0, rx_due_q8} + {9'd0, cfg_period};
            rx_due_q8 = sum[24] ? 24'hFFFFFF : sum[23:0];
        end
    endtask

    task automatic clear_byte_state();
        rx_nbits  = '0;
        rx_shift  = '0;
        rx_nbytes = '0;
    endtask

    task automatic queue_frame();
        logic [15:0] crc;
        logic [15:0] rx_sum;
        t_rx_byte    e;
        crc = 16'h0000;
        for (int i = 0; i + 2 < FRAME_BYTES; i++) crc = crc_step(crc, rx_store[i]);
        rx_sum = {rx_store[FRAME_BYTES-1], rx_store[FRAME_BYTES-2]};
        for (int k = 0; k < FRAME_BYTES; k++) begin
            e.value  = rx_store[k];
            e.index  = 4'(k);
            e.last   = (k == FRAME_BYTES - 1);
            e.crc_ok = (rx_sum == crc);
            pending_bytes.insert(pending_bytes.size(), e);
        end
    endtask

    task automatic decode_sample(input logic b);
        bit due;
        case (rx_phase)
            S_WAIT: begin
                if (b) begin
                    rx_phase = S_SYNC;
                    bump_tick();
                end
            end
            S_SYNC: begin
                if (b) begin
                    bump_tick();
                end else if (rx_ticks >= cfg_sync_min) begin
                    rx_phase  = S_START;
                    rx_ticks  = '0;
                    rx_due_q8 = {9'd0, cfg_half};
                end else begin
                    rx_phase = S_WAIT;
                    rx_ticks = '0;
                end
            end
            S_START: begin
                sample_due(due);
                if (due) begin
                    if (b) begin
                        rx_phase = S_IDLE;
                    end else begin
                        rx_phase = S_BIT;
                        clear_byte_state();
                    end
                end
            end
            S_BIT: begin
                sample_due(due);
                if (due) begin
                    if (rx_nbits < 8) begin
                        rx_shift = {b, rx_shift[7:1]};
                        rx_nbits++;
                    end else if (b) begin
                        rx_phase = S_IDLE;
                    end else begin
                        rx_store[rx_nbytes] = rx_shift;
                        rx_shift = '0;
                        rx_nbits = '0;
                        if (rx_nbytes + 1 >= FRAME_BYTES) begin
                            queue_frame();
                            clear_byte_state();
                            rx_phase = S_IDLE;
                        end else begin
                            rx_nbytes++;
                        end
                    end
                end
            end
            default: begin
                if (!b) begin
                    rx_phase = S_WAIT;
                    rx_ticks = '0;
                end else begin
                    rx_phase = S_IDLE;
                end
            end
        endcase
    endtask

    // sample source
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_s_tvalid || sample_taken)) begin
            if (src_gap > 0) begin
                src_gap--;
                i_s_tvalid <= 1'b0;
            end else if (sample_q.size() > 0) begin
                i_s_tdata  <= {7'd0, sample_q.pop_front()};
                i_s_tvalid <= 1'b1;
                src_gap = draw_gap();
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // byte sink with random back-pressure
    always @(negedge i_clk) begin
        if (sink_gap > 0) begin
            sink_gap--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
            if (byte_taken || $urandom_range(0, 9) == 0) sink_gap = draw_gap();
        end
    end

    always @(posedge i_clk) begin : observe
        t_rx_byte want;
        sample_taken = i_s_tvalid && o_s_tready;
        byte_taken   = o_m_tvalid && i_m_tready;
        if (!i_rst_n) begin
            reset_model();
        end else begin
            if (byte_taken) begin
                if (pending_bytes.size() == 0) begin
                    n_err++;
                    $display("%0t: unexpected byte, expected none, got data %0h last %0b crc_ok %0b",
                             $time, o_m_tdata, o_m_tlast, o_m_tuser);
                end else begin
                    want = pending_bytes.pop_front();
                    check_field("frame_byte", want.value, o_m_tdata[7:0]);
                    check_field("byte_index", want.index, o_m_tdata[11:8]);
                    check_field("last_byte", want.last, o_m_tlast);
                    check_field("crc_ok", want.crc_ok, o_m_tuser);
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_BIT_PERIOD: cfg_period   = i_cfg_data;
                    REG_HALF_BIT:   cfg_half     = i_cfg_data[14:0];
                    REG_SYNC_MIN:   cfg_sync_min = i_cfg_data;
                    default: ;
                endcase
            end
            if (sample_taken) decode_sample(i_s_tdata[0]);
        end
    end

    task automatic push_bit(input logic v);
        sample_q.insert(sample_q.size(), v);
        gen_count++;
    endtask

    task automatic push_noise(input int n);
        for (int i = 0; i < n; i++) push_bit(1'($urandom_range(0, 1)));
    endtask

    // kind: 0 zeros, 1 ones, 2 alternating, 3 random; bad CRC flips one bit, but kind 1 keeps ones
    task automatic make_payload(input int kind, input bit good_crc);
        logic [15:0] crc;
        for (int i = 0; i < FRAME_BYTES; i++) begin
            case (kind)
                0:       tx_bytes[i] = 8'h00;
                1:       tx_bytes[i] = 8'hFF;
                2:       tx_bytes[i] = i[0] ? 8'hAA : 8'h55;
                default: tx_bytes[i] = 8'($urandom);
            endcase
        end
        crc = 16'h0000;
        for (int i = 0; i + 2 < FRAME_BYTES; i++) crc = crc_step(crc, tx_bytes[i]);
        if (!good_crc) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
        if (good_crc || kind != 1) begin
            tx_bytes[FRAME_BYTES-2] = crc[7:0];
            tx_bytes[FRAME_BYTES-1] = crc[15:8];
        end
    endtask

    // Lays tx_bytes out over sample ticks at the current timing. A bad start bit or bad
    // separator ends the stream at that bit. Ticks that are not sampling instants may be flipped.
    task automatic add_frame(input int sync_len, input bit bad_start, input int bad_sep,
                             input int flip_pct);
        int  t;
        int  tk;
        int  j;
        logic bv;
        logic v;
        repeat ($urandom_range(1, 3)) push_bit(1'b0);
        repeat (sync_len) push_bit(1'b1);
        push_bit(1'b0);
        t = 1;
        for (int k = 0; k < FRAME_BITS; k++) begin
            j = k - 1;
            if (k == 0) bv = bad_start;
            else if (j % 9 < 8) bv = tx_bytes[j / 9][j % 9];
            else bv = (j / 9 == bad_sep);
            tk = (gen_half + k * gen_period + 255) / 256;
            while (t <= tk) begin
                v = bv;
                if (t < tk && $urandom_range(0, 99) < flip_pct) v = ~v;
                push_bit(v);
                t++;
            end
            if (k == 0 && bad_start) break;
            if (k > 0 && j % 9 == 8 && j / 9 == bad_sep) break;
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic set_regs(input int period, input int half, input int sync_min);
        write_reg(REG_BIT_PERIOD, CFG_DATA_W'(period));
        write_reg(REG_HALF_BIT, CFG_DATA_W'(half));
        write_reg(REG_SYNC_MIN, CFG_DATA_W'(sync_min));
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        gen_period = period;
        gen_half   = half;
    endtask

    // sender holds off until every queued sample is in and every predicted byte is out
    task automatic drain();
        while (sample_q.size() != 0 || i_s_tvalid || pending_bytes.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : stimulus
        int r;
        int sync_min;
        int period;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // fastest timing, shortest accepted sync
        set_regs(256, 128, 1);
        make_payload(2, 1'b1);
        add_frame(1, 1'b0, -1, 0);
        make_payload(3, 1'b1);
        add_frame(1, 1'b1, -1, 0);                  // start bit high
        make_payload(3, 1'b1);
        add_frame(3, 1'b0, 0, 0);                   // separator high on first byte
        make_payload(1, 1'b0);
        add_frame(2, 1'b0, -1, 0);
        drain();

        // random fractional timing, one frame or burst of noise per setting
        while (gen_count < N_ITEMS) begin
            gaps_on  = ($urandom_range(0, 3) != 0);
            period   = $urandom_range(256, 448);
            sync_min = $urandom_range(1, 8);
            set_regs(period, $urandom_range(128, period), sync_min);
            r = $urandom_range(0, 99);
            make_payload($urandom_range(0, 3), $urandom_range(0, 3) != 0);
            if (r < 60) begin
                add_frame(sync_min + $urandom_range(0, 4), 1'b0, -1, $urandom_range(0, 15));
            end else if (r < 70) begin
                add_frame(sync_min, 1'b1, -1, 5);
            end else if (r < 82) begin
                add_frame(sync_min, 1'b0, $urandom_range(0, FRAME_BYTES - 1), 5);
            end else if (r < 90) begin
                add_frame(sync_min > 1 ? sync_min - 1 : 1, 1'b0, -1, 5);
            end else begin
                push_noise($urandom_range(4, 40));
            end
            drain();
        end

        if (n_err == 0 && pending_bytes.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
src/sfbr_pkg.sv
src/sfbr_ram.sv
src/sfbr_ctrl.sv
src/sfbr_datapath.sv
src/sync_frame_bit_receiver.sv
dv/tb.sv
